// ===== rtl/e2r_pkg.sv =====
// Package: shared constants, arctangent table and pipeline types for the Euler-to-matrix block.
`default_nettype none
package e2r_pkg;
	localparam int ANG_W = 16;
	localparam int OUT_W = 16;
	localparam int FULL_TURN = 46080;
	localparam int QUARTER_TURN = 11520;
	localparam int PHASE_SCALE = 37480660;
	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int ATAN_ENTRIES = 24;
	localparam int OUT_FRAC = 14;
	localparam int OUT_ONE = 16384;
	localparam int CW = 33;

	typedef logic signed [CW-1:0] cval_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			default: r = 32'd1 << (30 - i);
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/e2r_cell.sv =====
// CORDIC cell: one rotation step for the three angles plus a quadrant carry.
`default_nettype none
module e2r_cell #(
	parameter int STEP = 0
) (
	input  wire                    clk,
	input  wire                    en,
	input  wire e2r_pkg::cval_t    x_in [3],
	input  wire e2r_pkg::cval_t    y_in [3],
	input  wire e2r_pkg::cval_t    z_in [3],
	input  wire [1:0]              q_in [3],
	output e2r_pkg::cval_t         x_out [3],
	output e2r_pkg::cval_t         y_out [3],
	output e2r_pkg::cval_t         z_out [3],
	output logic [1:0]             q_out [3]
);
	localparam e2r_pkg::cval_t ATAN = e2r_pkg::cval_t'({1'b0, e2r_pkg::atan_q30(STEP)});

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (!z_in[k][e2r_pkg::CW-1]) begin
					x_out[k] <= x_in[k] - (y_in[k] >>> STEP);
					y_out[k] <= y_in[k] + (x_in[k] >>> STEP);
					z_out[k] <= z_in[k] - ATAN;
				end else begin
					x_out[k] <= x_in[k] + (y_in[k] >>> STEP);
					y_out[k] <= y_in[k] - (x_in[k] >>> STEP);
					z_out[k] <= z_in[k] + ATAN;
				end
				q_out[k] <= q_in[k];
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/euler_to_rotation_matrix.sv =====
// Top level: angle reduction, CORDIC cell chain and matrix product pipeline.
// Usage: one angle triple enters on s_axis per transfer; one matrix leaves on
// m_axis per transfer, in input order.
// s_axis_tdata (lowest bit up): roll_deg[15:0], pitch_deg[15:0], yaw_deg[15:0].
// m_axis_tdata (lowest bit up): r00, r01, r02, r10, r11, r12, r20, r21, r22,
// 16 bits each.
// Throughput: one triple per cycle while m_axis is not stalled; the pipeline takes
// one item every clock unless frozen. Pipeline: two reduction stages, one cell per
// CORDIC step (capped at ATAN_ENTRIES cells), a rounding stage and four
// multiply/sum stages.
// Stall: the whole pipeline freezes while m_axis_tvalid is high and
// m_axis_tready low; s_axis_tready follows that (holds the last stage).
// Reset: arst_n clears all valid flags; no item is in flight afterward.
`default_nettype none
module euler_to_rotation_matrix #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 14
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire [47:0]   s_axis_tdata,   // roll_deg, pitch_deg, yaw_deg
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [143:0] m_axis_tdata    // r00,r01,r02,r10,r11,r12,r20,r21,r22
);
	localparam int NS = (CORDIC_STEPS < e2r_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
		: e2r_pkg::ATAN_ENTRIES;
	localparam int DEPTH = NS + 7;
	localparam int PW = 2 * FRAC_BITS + 4;
	localparam int SH1 = 30 - FRAC_BITS;
	localparam int SH2 = 2 * FRAC_BITS - e2r_pkg::OUT_FRAC;
	localparam logic signed [31:0] ONE = 32'sd1 << FRAC_BITS;

	logic en;
	logic [DEPTH-1:0] vld_q;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	// stage 1: wrap to [0, 360)
	logic [15:0] a_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [17:0] v;
				logic signed [17:0] m;
				v = 18'(signed'(s_axis_tdata[16*k +: 16]));
				m = v;
				if (m < 0) m = m + 18'sd46080;
				if (m < 0) m = m + 18'sd46080;
				if (m >= 18'sd46080) m = m - 18'sd46080;
				a_s1[k] <= m[15:0];
			end
		end
	end

	// stage 2: quadrant split and phase scaling
	e2r_pkg::cval_t x_c [NS+1][3];
	e2r_pkg::cval_t y_c [NS+1][3];
	e2r_pkg::cval_t z_c [NS+1][3];
	logic [1:0] q_c [NS+1][3];
	e2r_pkg::cval_t x_s2 [3];
	e2r_pkg::cval_t y_s2 [3];
	e2r_pkg::cval_t z_s2 [3];
	logic [1:0] q_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic [1:0] q;
				logic [15:0] r;
				logic [41:0] p;
				if (a_s1[k] >= 16'd34560) begin
					q = 2'd3; r = a_s1[k] - 16'd34560;
				end else if (a_s1[k] >= 16'd23040) begin
					q = 2'd2; r = a_s1[k] - 16'd23040;
				end else if (a_s1[k] >= 16'd11520) begin
					q = 2'd1; r = a_s1[k] - 16'd11520;
				end else begin
					q = 2'd0; r = a_s1[k];
				end
				p = 42'(r) * 42'(e2r_pkg::PHASE_SCALE) + 42'd128;
				z_s2[k] <= e2r_pkg::CW'(p >> 8);
				x_s2[k] <= e2r_pkg::CW'(e2r_pkg::CORDIC_GAIN_Q30);
				y_s2[k] <= '0;
				q_s2[k] <= q;
			end
		end
	end

	assign x_c[0] = x_s2;
	assign y_c[0] = y_s2;
	assign z_c[0] = z_s2;
	assign q_c[0] = q_s2;

	for (genvar i = 0; i < NS; i++) begin : g_cell
		e2r_cell #(.STEP(i)) u_cell (
			.clk(clk), .en(en),
			.x_in(x_c[i]), .y_in(y_c[i]), .z_in(z_c[i]), .q_in(q_c[i]),
			.x_out(x_c[i+1]), .y_out(y_c[i+1]), .z_out(z_c[i+1]), .q_out(q_c[i+1])
		);
	end

	// round, clamp, quadrant map: s,c for roll, pitch, yaw
	logic signed [FRAC_BITS+1:0] s_s3 [3];
	logic signed [FRAC_BITS+1:0] c_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [e2r_pkg::CW:0] cx, sy;
				logic signed [31:0] c, s;
				cx = (e2r_pkg::CW+1)'(x_c[NS][k]) + ((e2r_pkg::CW+1)'(1) <<< (SH1 - 1));
				sy = (e2r_pkg::CW+1)'(y_c[NS][k]) + ((e2r_pkg::CW+1)'(1) <<< (SH1 - 1));
				c = 32'(cx >>> SH1);
				s = 32'(sy >>> SH1);
				if (c > ONE) c = ONE;
				if (c < -ONE) c = -ONE;
				if (s > ONE) s = ONE;
				if (s < -ONE) s = -ONE;
				case (q_c[NS][k])
					2'd0: begin c_s3[k] <= (FRAC_BITS+2)'(c); s_s3[k] <= (FRAC_BITS+2)'(s); end
					2'd1: begin c_s3[k] <= (FRAC_BITS+2)'(-s); s_s3[k] <= (FRAC_BITS+2)'(c); end
					2'd2: begin c_s3[k] <= (FRAC_BITS+2)'(-c); s_s3[k] <= (FRAC_BITS+2)'(-s); end
					default: begin c_s3[k] <= (FRAC_BITS+2)'(s); s_s3[k] <= (FRAC_BITS+2)'(-c); end
				endcase
			end
		end
	end

	// product stage A: sp*sr, sp*cr and direct products
	logic signed [PW-1:0] spsr_s4, spcr_s4, cycp_s4, sycp_s4, spone_s4, cpsr_s4, cpcr_s4;
	logic signed [FRAC_BITS+1:0] sr_s4, cr_s4, sy_s4, cy_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			spsr_s4 <= PW'(s_s3[1] * s_s3[0]);
			spcr_s4 <= PW'(s_s3[1] * c_s3[0]);
			cycp_s4 <= PW'(c_s3[2] * c_s3[1]);
			sycp_s4 <= PW'(s_s3[2] * c_s3[1]);
			spone_s4 <= -(PW'(s_s3[1]) <<< FRAC_BITS);
			cpsr_s4 <= PW'(c_s3[1] * s_s3[0]);
			cpcr_s4 <= PW'(c_s3[1] * c_s3[0]);
			sr_s4 <= s_s3[0]; cr_s4 <= c_s3[0]; sy_s4 <= s_s3[2]; cy_s4 <= c_s3[2];
		end
	end

	// round sp products back to Q(FRAC_BITS)
	logic signed [FRAC_BITS+1:0] spsr_s5, spcr_s5, sr_s5, cr_s5, sy_s5, cy_s5;
	logic signed [PW-1:0] d_s5 [5];
	always_ff @(posedge clk) begin
		if (en) begin
			spsr_s5 <= (FRAC_BITS+2)'((spsr_s4 + (PW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
			spcr_s5 <= (FRAC_BITS+2)'((spcr_s4 + (PW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
			sr_s5 <= sr_s4; cr_s5 <= cr_s4; sy_s5 <= sy_s4; cy_s5 <= cy_s4;
			d_s5[0] <= cycp_s4; d_s5[1] <= sycp_s4; d_s5[2] <= spone_s4;
			d_s5[3] <= cpsr_s4; d_s5[4] <= cpcr_s4;
		end
	end

	// second products
	logic signed [PW-1:0] m_s6 [8];
	logic signed [PW-1:0] d_s6 [5];
	always_ff @(posedge clk) begin
		if (en) begin
			m_s6[0] <= PW'(cy_s5 * spsr_s5);
			m_s6[1] <= PW'(sy_s5 * cr_s5);
			m_s6[2] <= PW'(cy_s5 * spcr_s5);
			m_s6[3] <= PW'(sy_s5 * sr_s5);
			m_s6[4] <= PW'(sy_s5 * spsr_s5);
			m_s6[5] <= PW'(cy_s5 * cr_s5);
			m_s6[6] <= PW'(sy_s5 * spcr_s5);
			m_s6[7] <= PW'(cy_s5 * sr_s5);
			d_s6 <= d_s5;
		end
	end

	function automatic logic [15:0] finish(input logic signed [PW-1:0] v);
		logic signed [PW:0] t;
		t = (PW+1)'(v);
		if (SH2 > 0) t = (t + ((PW+1)'(1) <<< (SH2 > 0 ? SH2 - 1 : 0))) >>> SH2;
		else t = t <<< (-SH2);
		if (t > (PW+1)'(e2r_pkg::OUT_ONE)) t = (PW+1)'(e2r_pkg::OUT_ONE);
		if (t < -(PW+1)'(e2r_pkg::OUT_ONE)) t = -(PW+1)'(e2r_pkg::OUT_ONE);
		return t[15:0];
	endfunction

	// sums, rounding and output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata[0 +: 16] <= finish(d_s6[0]);
			m_axis_tdata[16 +: 16] <= finish(m_s6[0] - m_s6[1]);
			m_axis_tdata[32 +: 16] <= finish(m_s6[2] + m_s6[3]);
			m_axis_tdata[48 +: 16] <= finish(d_s6[1]);
			m_axis_tdata[64 +: 16] <= finish(m_s6[4] + m_s6[5]);
			m_axis_tdata[80 +: 16] <= finish(m_s6[6] - m_s6[7]);
			m_axis_tdata[96 +: 16] <= finish(d_s6[2]);
			m_axis_tdata[112 +: 16] <= finish(d_s6[3]);
			m_axis_tdata[128 +: 16] <= finish(d_s6[4]);
		end
	end
endmodule
`default_nettype wire
